[design/swst_pkg.sv]
`default_nettype none
package swst_pkg;

	localparam int FRAME_W    = 24;
	localparam int NUM_W      = 25;  // frame number plus one spare bit
	localparam int CNT_W      = 7;
	localparam int WIN_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'd1;

	localparam logic [FRAME_W-1:0] TOTAL_RESET  = 24'd1;
	localparam logic [WIN_W-1:0]   WINDOW_RESET = 7'd8;

	typedef enum logic [1:0] {
		ST_RETIRE  = 2'd0,
		ST_MARKED  = 2'd1,
		ST_IGNORED = 2'd2,
		ST_NOT_ACK = 2'd3
	} ack_status_t;

	typedef struct packed {
		logic        load_in;
		logic        eval;
		logic        send;
		logic        retire;
		logic        mark;
		logic        finish;
		logic        load_rsp;
		ack_status_t code;
	} swst_cmd_t;

	typedef struct packed {
		logic func;
		logic can_send;
		logic ack_ok;
		logic is_oldest;
		logic is_later;
		logic mark_free;
		logic drain_more;
		logic past_total;
	} swst_stat_t;

endpackage
`default_nettype wire

[design/swst_ifs.sv]
`default_nettype none
interface swst_req_if import swst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [FRAME_W-1:0] ack_frame;

	modport source (output valid, output func, output ack_frame, input ready);
	modport sink   (input valid, input func, input ack_frame, output ready);
endinterface

interface swst_rsp_if import swst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               send_valid;
	logic [FRAME_W-1:0] sent_frame;
	logic [1:0]         ack_status;
	logic [CNT_W-1:0]   retired_count;
	logic [CNT_W-1:0]   outstanding;
	logic               all_done;

	modport source (output valid, output send_valid, output sent_frame, output ack_status,
		output retired_count, output outstanding, output all_done, input ready);
	modport sink   (input valid, input send_valid, input sent_frame, input ack_status,
		input retired_count, input outstanding, input all_done, output ready);
endinterface
`default_nettype wire

[design/sliding_window_send_tracker_top.sv]
// Sliding-window sender with selective acknowledgement.
// Requests are handled one at a time: sends, marks and ignored acks alike; an in-order
// ack also retires the frames drained behind it, walked one per cycle over the bitmap.
// Each request is registered, evaluated, acted on (and drained), then its result is loaded.
// A new request is taken while an earlier result still waits in the output register.
// Reset (async, active low) clears window and bitmap, sets config defaults; no sweep.
`default_nettype none
module sliding_window_send_tracker_top import swst_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	swst_req_if.sink                   req,
	swst_rsp_if.source                 rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	swst_cmd_t  cmd;
	swst_stat_t stat;

	swst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	swst_dp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_data          (cfg_data),
		.in_func           (req.func),
		.in_ack_frame      (req.ack_frame),
		.cmd               (cmd),
		.stat              (stat),
		.out_send_valid    (rsp.send_valid),
		.out_sent_frame    (rsp.sent_frame),
		.out_ack_status    (rsp.ack_status),
		.out_retired_count (rsp.retired_count),
		.out_outstanding   (rsp.outstanding),
		.out_all_done      (rsp.all_done)
	);

endmodule
`default_nettype wire

[design/swst_ctrl.sv]
`default_nettype none
module swst_ctrl import swst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	input  wire swst_stat_t stat,
	output swst_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ACT,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t      state_q, state_d;
	ack_status_t status_q, status_d;
	logic        rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.code = status_q;
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_ACT;
			end
			S_ACT: begin
				state_d = S_FIN;
				if (!stat.func) begin
					status_d = ST_NOT_ACK;
					cmd.send = stat.can_send;
				end else if (!stat.ack_ok) begin
					status_d = ST_IGNORED;
				end else if (stat.is_oldest) begin
					status_d   = ST_RETIRE;
					cmd.retire = 1'b1;
					state_d    = S_DRAIN;
				end else if (stat.is_later && stat.mark_free) begin
					status_d = ST_MARKED;
					cmd.mark = 1'b1;
				end else begin
					status_d = ST_IGNORED;
				end
			end
			S_DRAIN: begin
				// walk forward over frames already received out of order
				if (stat.drain_more) begin
					cmd.retire = 1'b1;
				end else begin
					cmd.finish = stat.past_total;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_NOT_ACK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.send, cmd.retire, cmd.mark, cmd.finish, cmd.load_rsp}))
		else $error("more than one datapath action in a cycle");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_EVAL))
		else $error("accepted request not evaluated");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !cmd.load_rsp)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

[design/swst_dp.sv]
`default_nettype none
module swst_dp import swst_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_func,
	input  wire logic [FRAME_W-1:0]    in_ack_frame,
	input  wire swst_cmd_t             cmd,
	output swst_stat_t                 stat,
	output logic                       out_send_valid,
	output logic [FRAME_W-1:0]         out_sent_frame,
	output logic [1:0]                 out_ack_status,
	output logic [CNT_W-1:0]           out_retired_count,
	output logic [CNT_W-1:0]           out_outstanding,
	output logic                       out_all_done
);

	localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW_MAX - 1);
	localparam logic [SW:0]   SLOT_MOD  = (SW+1)'(WINDOW_MAX);
	localparam logic [NUM_W-1:0] WMAX_N = NUM_W'(WINDOW_MAX);

	logic [FRAME_W-1:0]    total_q;
	logic [WIN_W-1:0]      window_q;
	logic [NUM_W-1:0]      next_q, oldest_q;
	logic [SW-1:0]         slot_next_q, slot_old_q;
	logic [WINDOW_MAX-1:0] mask_q;
	logic                  finished_q;

	logic                  func_q;
	logic [FRAME_W-1:0]    ack_q;
	logic                  can_send_q, ack_ok_q, is_oldest_q, is_later_q;
	logic [SW-1:0]         diff_q;
	logic                  sent_q;
	logic [FRAME_W-1:0]    sent_frame_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  rsp_send_q, rsp_done_q;
	logic [FRAME_W-1:0]    rsp_frame_q;
	logic [1:0]            rsp_status_q;
	logic [CNT_W-1:0]      rsp_cnt_q, rsp_outs_q;

	logic [NUM_W-1:0] eff_win, outs, ack_n;
	logic [SW:0]      ack_sum;
	logic [SW-1:0]    ack_slot;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	always_comb begin
		if (window_q == '0)
			eff_win = NUM_W'(1);
		else if ({25'd0, window_q} > 32'(WINDOW_MAX))
			eff_win = WMAX_N;
		else
			eff_win = NUM_W'(window_q);
	end

	assign outs  = next_q - oldest_q;
	assign ack_n = {1'b0, ack_q};

	// ack lies within the window here, so its offset from the oldest is below WINDOW_MAX
	assign ack_sum  = {1'b0, slot_old_q} + {1'b0, diff_q};
	assign ack_slot = (ack_sum >= SLOT_MOD) ? SW'(ack_sum - SLOT_MOD) : ack_sum[SW-1:0];

	always_comb begin
		stat            = '0;
		stat.func       = func_q;
		stat.can_send   = can_send_q;
		stat.ack_ok     = ack_ok_q;
		stat.is_oldest  = is_oldest_q;
		stat.is_later   = is_later_q;
		stat.mark_free  = !mask_q[ack_slot];
		stat.drain_more = (oldest_q < next_q) && mask_q[slot_old_q];
		stat.past_total = (oldest_q > {1'b0, total_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			ack_q  <= in_ack_frame;
		end
		if (cmd.eval) begin
			can_send_q  <= !finished_q && (outs < eff_win) && (next_q <= {1'b0, total_q});
			ack_ok_q    <= !finished_q && (ack_q != '0) && (ack_n < next_q);
			is_oldest_q <= (ack_n == oldest_q);
			is_later_q  <= (ack_n > oldest_q);
			diff_q      <= SW'(ack_n - oldest_q);
		end
		if (cmd.load_rsp) begin
			rsp_send_q   <= sent_q;
			rsp_frame_q  <= sent_frame_q;
			rsp_status_q <= cmd.code;
			rsp_cnt_q    <= cnt_q;
			rsp_outs_q   <= outs[CNT_W-1:0];
			rsp_done_q   <= finished_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= TOTAL_RESET;
			window_q     <= WINDOW_RESET;
			next_q       <= NUM_W'(1);
			oldest_q     <= NUM_W'(1);
			slot_next_q  <= '0;
			slot_old_q   <= '0;
			mask_q       <= '0;
			finished_q   <= 1'b0;
			sent_q       <= 1'b0;
			sent_frame_q <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TOTAL_FRAMES: total_q  <= cfg_data;
					REG_WINDOW_SIZE:  window_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				sent_q       <= 1'b0;
				sent_frame_q <= '0;
				cnt_q        <= '0;
			end
			if (cmd.send) begin
				sent_q              <= 1'b1;
				sent_frame_q        <= next_q[FRAME_W-1:0];
				mask_q[slot_next_q] <= 1'b0;
				next_q              <= next_q + 1'b1;
				slot_next_q         <= slot_inc(slot_next_q);
			end
			if (cmd.retire) begin
				mask_q[slot_old_q] <= 1'b0;
				oldest_q           <= oldest_q + 1'b1;
				slot_old_q         <= slot_inc(slot_old_q);
				cnt_q              <= cnt_q + 1'b1;
			end
			if (cmd.mark)
				mask_q[ack_slot] <= 1'b1;
			if (cmd.finish)
				finished_q <= 1'b1;
		end
	end

	assign out_send_valid    = rsp_send_q;
	assign out_sent_frame    = rsp_frame_q;
	assign out_ack_status    = rsp_status_q;
	assign out_retired_count = rsp_cnt_q;
	assign out_outstanding   = rsp_outs_q;
	assign out_all_done      = rsp_done_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q <= next_q)
		else $error("oldest frame passed next frame");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		outs <= WMAX_N)
		else $error("outstanding frames exceed window capacity");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> ($stable(next_q) && $stable(oldest_q)))
		else $error("window moved after completion");

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
	import swst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_MAX      = 64;
	localparam int DRAIN_CYCLES = 80;       // longest in-order ack: one retired and 63 drained frames
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 500_000;

	localparam logic FUNC_SEND = 1'b0;
	localparam logic FUNC_ACK  = 1'b1;

	typedef struct packed {
		logic               send_valid;
		logic [FRAME_W-1:0] sent_frame;
		ack_status_t        status;
		logic [CNT_W-1:0]   retired_count;
		logic [CNT_W-1:0]   outstanding;
		logic               all_done;
	} window_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	swst_req_if req_bus ();
	swst_rsp_if rsp_bus ();

	sliding_window_send_tracker_top #(.WINDOW_MAX(WIN_MAX)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_bus),
		.rsp      (rsp_bus),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// predicted window state and registers
	logic [NUM_W-1:0]   m_next;
	logic [NUM_W-1:0]   m_oldest;
	logic [WIN_MAX-1:0] m_mask;
	logic               m_finished;
	logic [FRAME_W-1:0] m_total;
	logic [WIN_W-1:0]   m_window;

	window_result_t results_due[$];
	int             mismatches;
	int             cycle_count;
	bit             calm;
	bit             hold_rsp;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic int mask_slot(input logic [NUM_W-1:0] frame);
		return int'(frame % WIN_MAX);
	endfunction

	function automatic window_result_t advance_window(input logic func,
			input logic [FRAME_W-1:0] ack);
		window_result_t   r;
		logic [NUM_W-1:0] a;
		logic [WIN_W-1:0] win;
		r = '0;
		r.status = ST_NOT_ACK;
		a = {1'b0, ack};
		win = (m_window == '0) ? WIN_W'(1) :
			(m_window > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : m_window;
		if (func == FUNC_SEND) begin
			if (!m_finished && (m_next - m_oldest) < win && m_next <= {1'b0, m_total}) begin
				r.send_valid = 1'b1;
				r.sent_frame = m_next[FRAME_W-1:0];
				m_mask[mask_slot(m_next)] = 1'b0;
				m_next++;
			end
		end else begin
			r.status = ST_IGNORED;
			if (!m_finished && a != '0 && a < m_next) begin
				if (a == m_oldest) begin
					r.status = ST_RETIRE;
					m_mask[mask_slot(a)] = 1'b0;
					m_oldest++;
					r.retired_count = CNT_W'(1);
					// walk forward over frames already marked
					while (m_oldest < m_next && m_mask[mask_slot(m_oldest)]) begin
						m_mask[mask_slot(m_oldest)] = 1'b0;
						m_oldest++;
						r.retired_count = r.retired_count + 1'b1;
					end
					if (m_oldest > {1'b0, m_total})
						m_finished = 1'b1;
				end else if (a > m_oldest && !m_mask[mask_slot(a)]) begin
					r.status = ST_MARKED;
					m_mask[mask_slot(a)] = 1'b1;
				end
			end
		end
		r.outstanding = CNT_W'(m_next - m_oldest);
		r.all_done = m_finished;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [FRAME_W-1:0] want,
			input logic [FRAME_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		window_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (results_due.size() == 0) begin
				$error("response with no request pending");
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("send_valid", want.send_valid, rsp_bus.send_valid);
				check_field("sent_frame", want.sent_frame, rsp_bus.sent_frame);
				check_field("ack_status", want.status, rsp_bus.ack_status);
				check_field("retired_count", want.retired_count, rsp_bus.retired_count);
				check_field("outstanding", want.outstanding, rsp_bus.outstanding);
				check_field("all_done", want.all_done, rsp_bus.all_done);
			end
		end
	end

	// response side: random stalls, plus one long hold-off when asked
	initial begin : response_sink
		int stall;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
		end
	end

	task automatic put_request(input logic func, input logic [FRAME_W-1:0] frame);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.func <= func;
		req_bus.ack_frame <= frame;
		do @(posedge clk); while (!req_bus.ready);
		results_due.insert(results_due.size(), advance_window(func, frame));
	endtask

	task automatic settle();
		req_bus.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_TOTAL_FRAMES)
			m_total = data[FRAME_W-1:0];
		else if (idx == REG_WINDOW_SIZE)
			m_window = data[WIN_W-1:0];
	endtask

	// mostly sends and acks of outstanding frames; some noise acks
	task automatic random_request();
		int                 pick;
		int                 outs;
		logic [FRAME_W-1:0] frame;
		outs = int'(m_next - m_oldest);
		pick = $urandom_range(0, 99);
		frame = FRAME_W'($urandom());
		if (pick < 45 || outs == 0)
			put_request(FUNC_SEND, frame);
		else if (pick < 70)
			put_request(FUNC_ACK, m_oldest[FRAME_W-1:0]);
		else if (pick < 88)
			put_request(FUNC_ACK, m_oldest[FRAME_W-1:0] + FRAME_W'($urandom_range(0, outs - 1)));
		else begin
			case ($urandom_range(0, 3))
				0: put_request(FUNC_ACK, '0);
				1: put_request(FUNC_ACK, m_oldest[FRAME_W-1:0] - FRAME_W'($urandom_range(1, 8)));
				2: put_request(FUNC_ACK, m_next[FRAME_W-1:0] + FRAME_W'($urandom_range(0, 8)));
				default: put_request(FUNC_ACK, frame);
			endcase
		end
	endtask

	task automatic test_reset_state();
		put_request(FUNC_SEND, '1);
		put_request(FUNC_SEND, '0);            // total of one already sent
		put_request(FUNC_ACK, '0);
		put_request(FUNC_ACK, FRAME_W'(2));    // not sent yet
		put_request(FUNC_ACK, '1);
	endtask

	task automatic test_window_limits();
		settle();
		write_reg(REG_TOTAL_FRAMES, '1);
		write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(1));
		put_request(FUNC_SEND, '0);
		put_request(FUNC_ACK, FRAME_W'(1));
		put_request(FUNC_SEND, '0);
		put_request(FUNC_SEND, '0);
		settle();
		write_reg(REG_WINDOW_SIZE, '0);        // zero window behaves as one
		put_request(FUNC_SEND, '0);
		put_request(FUNC_ACK, FRAME_W'(2));
		put_request(FUNC_SEND, '0);
	endtask

	task automatic test_selective_ack();
		settle();
		write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(4));
		repeat (4) put_request(FUNC_SEND, FRAME_W'($urandom()));
		put_request(FUNC_ACK, FRAME_W'(5));
		put_request(FUNC_ACK, FRAME_W'(5));    // already marked
		put_request(FUNC_ACK, FRAME_W'(6));
		put_request(FUNC_ACK, FRAME_W'(4));
		put_request(FUNC_ACK, FRAME_W'(3));    // retires 3 and drains 4..6
		put_request(FUNC_ACK, FRAME_W'(3));
		put_request(FUNC_ACK, FRAME_W'(7));
	endtask

	task automatic test_zero_total();
		settle();
		write_reg(REG_TOTAL_FRAMES, '0);
		put_request(FUNC_SEND, '0);
		put_request(FUNC_SEND, '1);
		settle();
		write_reg(REG_TOTAL_FRAMES, '1);
	endtask

	task automatic test_random_traffic();
		logic [WIN_W-1:0] windows[5];
		windows = '{WIN_W'(1), WIN_W'(64), WIN_W'(127), WIN_W'(0),
			WIN_W'($urandom_range(2, 63))};
		foreach (windows[i]) begin
			settle();
			write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(windows[i]));
			calm = (i == 2);
			repeat (170) random_request();
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		settle();
		write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(64));
		calm = 1'b1;
		hold_rsp = 1'b1;
		repeat (80) random_request();
		calm = 1'b0;
	endtask

	// lowered total, last frame marked and reached by draining, then requests after done
	task automatic test_finish_by_draining();
		logic [FRAME_W-1:0] base;
		while (m_next != m_oldest) put_request(FUNC_ACK, m_oldest[FRAME_W-1:0]);
		base = m_oldest[FRAME_W-1:0];
		repeat (4) put_request(FUNC_SEND, FRAME_W'($urandom()));
		settle();
		write_reg(REG_TOTAL_FRAMES, CFG_DATA_W'(base + 1));
		put_request(FUNC_SEND, '0);
		put_request(FUNC_ACK, base + 3);
		put_request(FUNC_ACK, base + 1);
		put_request(FUNC_ACK, base);
		put_request(FUNC_SEND, '0);
		put_request(FUNC_ACK, base + 2);
		put_request(FUNC_ACK, '1);
	endtask

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.func = FUNC_SEND;
		req_bus.ack_frame = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_TOTAL_FRAMES;
		cfg_data = '0;
		mismatches = 0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		m_next = NUM_W'(1);
		m_oldest = NUM_W'(1);
		m_mask = '0;
		m_finished = 1'b0;
		m_total = TOTAL_RESET;
		m_window = WINDOW_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_window_limits();
		test_selective_ack();
		test_zero_total();
		test_random_traffic();
		test_backpressure();
		test_finish_by_draining();
		settle();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
design/swst_pkg.sv
design/swst_ifs.sv
design/swst_ctrl.sv
design/swst_dp.sv
design/sliding_window_send_tracker_top.sv
tb/testbench.sv
